// ===== design/hrc_pkg.sv =====
package hrc_pkg;

  localparam int HEIGHT_W = 24;
  localparam int COUNT_W = 23;
  localparam int RANK_FIELD_W = 2;
  localparam int REG_W = 49;
  localparam int REG_MIN_LSB = 0;
  localparam int REG_MAX_LSB = 24;
  localparam int REG_EN_BIT = 48;
  localparam int NUM_REGS = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_LSB = 3;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 32;
  localparam int NUM_RANGES_DEF = 4;
  localparam int MAX_FRAME_PIXELS_DEF = 4194304;
  localparam int COUNT_MAX = 8388607;

  typedef enum logic {
    KIND_CLASS  = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] lo;
    logic signed [HEIGHT_W-1:0] hi;
    logic                       en;
    logic                       incl_max;
  } range_ent_t;

endpackage

// ===== design/hrc_cfg.sv =====
module hrc_cfg #(
  parameter int NUM_RANGES = hrc_pkg::NUM_RANGES_DEF,
  parameter int RW = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hrc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [hrc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output hrc_pkg::range_ent_t             tab_o [NUM_RANGES],
  output logic [RW-1:0]                   ord_o [NUM_RANGES]
);

  localparam int IDX_W = hrc_pkg::CFG_ADDR_W - hrc_pkg::CFG_IDX_LSB;
  localparam int H = hrc_pkg::HEIGHT_W;

  logic [hrc_pkg::REG_W-1:0] regs_r [NUM_RANGES];
  logic [IDX_W-1:0]          widx;
  logic                      wr_en;

  logic signed [H-1:0]  lo [NUM_RANGES];
  logic signed [H-1:0]  hi [NUM_RANGES];
  logic                 en [NUM_RANGES];
  logic [RW-1:0]        rank [NUM_RANGES];
  hrc_pkg::range_ent_t  tab_nxt [NUM_RANGES];
  logic [RW-1:0]        ord_nxt [NUM_RANGES];
  hrc_pkg::range_ent_t  tab_r [NUM_RANGES];
  logic [RW-1:0]        ord_r [NUM_RANGES];
  logic [RW-1:0]        top;

  function automatic logic key_less(input logic signed [H-1:0] amin,
                                    input logic signed [H-1:0] amax, input int ai,
                                    input logic signed [H-1:0] bmin,
                                    input logic signed [H-1:0] bmax, input int bi);
    logic res;
    if (amin != bmin) begin
      res = amin < bmin;
    end else if (amax != bmax) begin
      res = amax < bmax;
    end else begin
      res = ai < bi;
    end
    return res;
  endfunction

  assign cfg_pready = 1'b1;
  assign widx = cfg_paddr[hrc_pkg::CFG_ADDR_W-1:hrc_pkg::CFG_IDX_LSB];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RANGES; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (i < hrc_pkg::NUM_REGS && widx == IDX_W'(i)) begin
          regs_r[i] <= cfg_pwdata[hrc_pkg::REG_W-1:0];
        end
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (i < hrc_pkg::NUM_REGS && widx == IDX_W'(i)) begin
        cfg_prdata = hrc_pkg::CFG_DATA_W'(regs_r[i]);
      end
    end
  end

  // Normalize the bounds and rank every range by (min, max, register index).
  always_comb begin
    logic signed [H-1:0] a;
    logic signed [H-1:0] b;
    for (int i = 0; i < NUM_RANGES; i++) begin
      a = $signed(regs_r[i][hrc_pkg::REG_MIN_LSB +: H]);
      b = $signed(regs_r[i][hrc_pkg::REG_MAX_LSB +: H]);
      lo[i] = (a < b) ? a : b;
      hi[i] = (a < b) ? b : a;
      en[i] = regs_r[i][hrc_pkg::REG_EN_BIT];
    end
    for (int i = 0; i < NUM_RANGES; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NUM_RANGES; j++) begin
        if (j != i && key_less(lo[j], hi[j], j, lo[i], hi[i], i)) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    for (int r = 0; r < NUM_RANGES; r++) begin
      tab_nxt[r] = '0;
      ord_nxt[r] = '0;
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (rank[i] == RW'(r)) begin
          ord_nxt[r]    = RW'(i);
          tab_nxt[r].lo = lo[i];
          tab_nxt[r].hi = hi[i];
          tab_nxt[r].en = en[i];
        end
      end
    end
    top = '0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (tab_nxt[r].en) begin
        top = RW'(r);
      end
    end
    for (int r = 0; r < NUM_RANGES; r++) begin
      tab_nxt[r].incl_max = tab_nxt[r].en && (top == RW'(r));
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_RANGES; r++) begin
      tab_r[r] <= tab_nxt[r];
      ord_r[r] <= ord_nxt[r];
    end
  end

  assign tab_o = tab_r;
  assign ord_o = ord_r;

endmodule

// ===== design/hrc_match.sv =====
module hrc_match #(
  parameter int NUM_RANGES = hrc_pkg::NUM_RANGES_DEF,
  parameter int RW = 2
) (
  input  logic signed [hrc_pkg::HEIGHT_W-1:0] height_i,
  input  hrc_pkg::range_ent_t                 tab_i [NUM_RANGES],
  input  logic [RW-1:0]                       ord_i [NUM_RANGES],
  output logic                                hit_o,
  output logic [RW-1:0]                       hit_rank_o,
  output logic [NUM_RANGES-1:0]               hit_sel_o
);

  logic [RW-1:0] hit_reg;

  always_comb begin
    logic in_range;
    hit_o      = 1'b0;
    hit_rank_o = '0;
    hit_reg    = '0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      in_range = tab_i[r].en && (height_i >= tab_i[r].lo) &&
                 (tab_i[r].incl_max ? (height_i <= tab_i[r].hi) : (height_i < tab_i[r].hi));
      if (in_range && !hit_o) begin
        hit_o      = 1'b1;
        hit_rank_o = RW'(r);
        hit_reg    = ord_i[r];
      end
    end
    for (int i = 0; i < NUM_RANGES; i++) begin
      hit_sel_o[i] = hit_o && (hit_reg == RW'(i));
    end
  end

endmodule

// ===== design/hrc_core.sv =====
module hrc_core #(
  parameter int NUM_RANGES = hrc_pkg::NUM_RANGES_DEF,
  parameter int RW = 2,
  parameter int COUNT_CAP = hrc_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [hrc_pkg::HEIGHT_W-1:0] in_height_cm,
  input  logic                                in_frame_end,
  output logic signed [hrc_pkg::HEIGHT_W-1:0] stg_height_o,
  input  logic                                hit_i,
  input  logic [RW-1:0]                       hit_rank_i,
  input  logic [NUM_RANGES-1:0]               hit_sel_i,
  input  logic [RW-1:0]                       ord_i [NUM_RANGES],
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output hrc_pkg::kind_t                      out_report_kind,
  output logic [hrc_pkg::RANK_FIELD_W-1:0]    out_range_rank,
  output logic                                out_matched,
  output logic [hrc_pkg::COUNT_W-1:0]         out_pixel_count,
  output logic                                out_last_of_run
);

  localparam int CW = hrc_pkg::COUNT_W;
  localparam int RKW = (RW > hrc_pkg::RANK_FIELD_W) ? RW : hrc_pkg::RANK_FIELD_W;
  localparam logic [CW-1:0] CAP = CW'(COUNT_CAP);

  logic                               stg_valid_r;
  logic signed [hrc_pkg::HEIGHT_W-1:0] stg_h_r;
  logic                               stg_fend_r;
  logic                               stg_rep_r;
  logic [RW-1:0]                      step_r;
  logic [CW-1:0]                      cnt_r [NUM_RANGES];

  logic                               out_valid_r;
  hrc_pkg::kind_t                     out_kind_r;
  logic [hrc_pkg::RANK_FIELD_W-1:0]   out_rank_r;
  logic                               out_matched_r;
  logic [CW-1:0]                      out_count_r;
  logic                               out_last_r;

  logic          out_adv;
  logic          emit;
  logic          step_last;
  logic          stg_free;
  logic          in_fire;
  logic [RW-1:0] rep_reg;
  logic [CW-1:0] rep_count;
  logic [RKW-1:0] rank_nxt;

  assign out_adv   = !out_valid_r || out_tready;
  assign emit      = stg_valid_r && out_adv;
  assign step_last = (step_r == RW'(NUM_RANGES - 1));
  assign stg_free  = emit && (stg_rep_r ? step_last : !stg_fend_r);
  assign in_tready = !stg_valid_r || stg_free;
  assign in_fire   = in_tvalid && in_tready;
  assign stg_height_o = stg_h_r;

  always_comb begin
    rep_reg   = '0;
    rep_count = '0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (step_r == RW'(r)) begin
        rep_reg = ord_i[r];
      end
    end
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (rep_reg == RW'(i)) begin
        rep_count = cnt_r[i];
      end
    end
    rank_nxt = stg_rep_r ? RKW'(step_r) : RKW'(hit_rank_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      stg_rep_r   <= 1'b0;
      step_r      <= '0;
    end else begin
      stg_valid_r <= in_fire || (stg_valid_r && !stg_free);
      if (emit) begin
        if (!stg_rep_r) begin
          if (stg_fend_r) begin
            stg_rep_r <= 1'b1;
            step_r    <= '0;
          end
        end else if (step_last) begin
          stg_rep_r <= 1'b0;
          step_r    <= '0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_h_r    <= in_height_cm;
      stg_fend_r <= in_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RANGES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (emit && stg_rep_r && step_last) begin
          cnt_r[i] <= '0;
        end else if (emit && !stg_rep_r && hit_sel_i[i] && cnt_r[i] < CAP) begin
          cnt_r[i] <= cnt_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r    <= stg_rep_r ? hrc_pkg::KIND_REPORT : hrc_pkg::KIND_CLASS;
      out_rank_r    <= rank_nxt[hrc_pkg::RANK_FIELD_W-1:0];
      out_matched_r <= !stg_rep_r && hit_i;
      out_count_r   <= stg_rep_r ? rep_count : '0;
      out_last_r    <= stg_rep_r ? step_last : !stg_fend_r;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_report_kind = out_kind_r;
  assign out_range_rank  = out_rank_r;
  assign out_matched     = out_matched_r;
  assign out_pixel_count = out_count_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== design/height_range_classifier.sv =====
// Height range classifier with per-range frame counts.
// Samples enter on the in_ stream as signed centimetre heights; in_tlast marks
// the last sample of a frame. Each sample yields one classification transaction
// on the out_ stream with the rank of the first enabled range that holds it.
// After the last sample of a frame, one count report per range follows in rank
// order, and the range counters are cleared. out_tlast marks the final result
// of each input transaction, and out_tuser tells classifications from reports.
// The four ranges are written through the APB-style cfg_ port at byte
// addresses 0, 8, 16 and 24; the ranking tables are then registered from them.
// A sample is registered on acceptance and its result is then registered in
// the output register. One sample is taken every cycle while the output
// register can advance; a frame's last sample holds the input stage until all
// of its results have gone out through the single output register.
// Reset clears the range registers, the counters and both pipeline stages.
// When the receiver stalls, the result waits in the output register, an empty
// input stage can still take one more sample, and in_tready then drops.
module height_range_classifier #(
  parameter int NUM_RANGES = hrc_pkg::NUM_RANGES_DEF,
  parameter int MAX_FRAME_PIXELS = hrc_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hrc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [hrc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hrc_pkg::IN_DATA_W-1:0]   in_tdata,   // [23:0] height_cm
  input  logic                            in_tlast,   // frame_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] range_rank, [2] matched, [25:3] pixel_count, [31:26] zero
  output logic [hrc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [0:0]                      out_tuser,  // [0] report_kind
  output logic                            out_tlast   // last_of_run
);

  localparam int RW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int COUNT_CAP = (MAX_FRAME_PIXELS < hrc_pkg::COUNT_MAX) ?
                             MAX_FRAME_PIXELS : hrc_pkg::COUNT_MAX;
  localparam int PAD_W = hrc_pkg::OUT_DATA_W - hrc_pkg::RANK_FIELD_W - 1 - hrc_pkg::COUNT_W;

  hrc_pkg::range_ent_t                 tab [NUM_RANGES];
  logic [RW-1:0]                       ord [NUM_RANGES];
  logic signed [hrc_pkg::HEIGHT_W-1:0] stg_height;
  logic                                hit;
  logic [RW-1:0]                       hit_rank;
  logic [NUM_RANGES-1:0]               hit_sel;
  hrc_pkg::kind_t                      report_kind;
  logic [hrc_pkg::RANK_FIELD_W-1:0]    range_rank;
  logic                                matched;
  logic [hrc_pkg::COUNT_W-1:0]         pixel_count;

  hrc_cfg #(
    .NUM_RANGES (NUM_RANGES),
    .RW         (RW)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .tab_o       (tab),
    .ord_o       (ord)
  );

  hrc_match #(
    .NUM_RANGES (NUM_RANGES),
    .RW         (RW)
  ) u_match (
    .height_i   (stg_height),
    .tab_i      (tab),
    .ord_i      (ord),
    .hit_o      (hit),
    .hit_rank_o (hit_rank),
    .hit_sel_o  (hit_sel)
  );

  hrc_core #(
    .NUM_RANGES (NUM_RANGES),
    .RW         (RW),
    .COUNT_CAP  (COUNT_CAP)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_height_cm    ($signed(in_tdata[hrc_pkg::HEIGHT_W-1:0])),
    .in_frame_end    (in_tlast),
    .stg_height_o    (stg_height),
    .hit_i           (hit),
    .hit_rank_i      (hit_rank),
    .hit_sel_i       (hit_sel),
    .ord_i           (ord),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_report_kind (report_kind),
    .out_range_rank  (range_rank),
    .out_matched     (matched),
    .out_pixel_count (pixel_count),
    .out_last_of_run (out_tlast)
  );

  assign out_tdata = {{PAD_W{1'b0}}, pixel_count, matched, range_rank};
  assign out_tuser = report_kind;

endmodule

// ===== tb/sv/hrc_checker.sv =====
module hrc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hrc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hrc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [hrc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                           cfg_pready,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hrc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [hrc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [0:0]                     out_tuser,
  input  logic                           out_tlast,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrc_pkg::*;

  localparam int NR = NUM_RANGES_DEF;
  localparam int COUNT_CAP = (MAX_FRAME_PIXELS_DEF < COUNT_MAX) ? MAX_FRAME_PIXELS_DEF : COUNT_MAX;

  typedef struct packed {
    kind_t                   kind;
    logic [RANK_FIELD_W-1:0] rank;
    logic                    matched;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } result_t;

  logic [REG_W-1:0]   range_reg [NR];
  logic [COUNT_W-1:0] range_count [NR];
  result_t            expected_results [$];
  result_t            want;
  result_t            got;
  logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] reg_idx;
  int                 errors;

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic classify_sample(input logic signed [HEIGHT_W-1:0] h, input logic fend);
    logic signed [HEIGHT_W-1:0] a;
    logic signed [HEIGHT_W-1:0] b;
    logic signed [HEIGHT_W-1:0] lo [NR];
    logic signed [HEIGHT_W-1:0] hi [NR];
    logic                       en [NR];
    int                         order [NR];
    int                         r;
    int                         top;
    int                         hit;
    int                         g;
    result_t                    res;
    for (int i = 0; i < NR; i++) begin
      a = range_reg[i][REG_MIN_LSB +: HEIGHT_W];
      b = range_reg[i][REG_MAX_LSB +: HEIGHT_W];
      lo[i] = (a < b) ? a : b;
      hi[i] = (a < b) ? b : a;
      en[i] = range_reg[i][REG_EN_BIT];
    end
    for (int i = 0; i < NR; i++) begin
      r = 0;
      for (int j = 0; j < NR; j++) begin
        if (j != i && ((lo[j] < lo[i]) || (lo[j] == lo[i] && hi[j] < hi[i]) ||
                       (lo[j] == lo[i] && hi[j] == hi[i] && j < i))) begin
          r++;
        end
      end
      order[r] = i;
    end
    top = -1;
    for (int k = 0; k < NR; k++) begin
      if (en[order[k]]) begin
        top = k;
      end
    end
    hit = -1;
    for (int k = 0; k < NR; k++) begin
      g = order[k];
      if (hit < 0 && en[g] && h >= lo[g] && ((k == top) ? (h <= hi[g]) : (h < hi[g]))) begin
        hit = k;
      end
    end
    res.kind = KIND_CLASS;
    res.count = '0;
    res.last = !fend;
    if (hit >= 0) begin
      g = order[hit];
      if (range_count[g] < COUNT_CAP) begin
        range_count[g] = range_count[g] + 1'b1;
      end
      res.rank = RANK_FIELD_W'(hit);
      res.matched = 1'b1;
    end else begin
      res.rank = '0;
      res.matched = 1'b0;
    end
    expected_results.push_back(res);
    if (fend) begin
      for (int k = 0; k < NR; k++) begin
        res.kind = KIND_REPORT;
        res.rank = RANK_FIELD_W'(k);
        res.matched = 1'b0;
        res.count = range_count[order[k]];
        res.last = (k == NR - 1);
        expected_results.push_back(res);
      end
      for (int i = 0; i < NR; i++) begin
        range_count[i] = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NR; i++) begin
        range_reg[i] = '0;
        range_count[i] = '0;
      end
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        reg_idx = cfg_paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
        if (cfg_pwrite) begin
          if (reg_idx < NR) begin
            range_reg[reg_idx] = cfg_pwdata[REG_W-1:0];
          end
        end else if (reg_idx < NR && cfg_prdata !== CFG_DATA_W'(range_reg[reg_idx])) begin
          note_mismatch($sformatf("register %0d read: expected %h, got %h",
                                  reg_idx, CFG_DATA_W'(range_reg[reg_idx]), cfg_prdata));
        end
      end
      if (out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser[0]);
        got.rank = out_tdata[1:0];
        got.matched = out_tdata[2];
        got.count = out_tdata[25:3];
        got.last = out_tlast;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result with none expected: kind=%0d rank=%0d matched=%0d count=%0d last=%0d",
                                  got.kind, got.rank, got.matched, got.count, got.last));
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[31:26] !== '0) begin
            note_mismatch($sformatf(
              "expected kind=%0d rank=%0d matched=%0d count=%0d last=%0d, got kind=%0d rank=%0d matched=%0d count=%0d last=%0d pad=%h",
              want.kind, want.rank, want.matched, want.count, want.last,
              got.kind, got.rank, got.matched, got.count, got.last, out_tdata[31:26]));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        classify_sample(in_tdata, in_tlast);
      end
    end
    fail_count <= errors;
    pending <= expected_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrc_pkg::*;

  localparam int LONG_HOLD = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    pending;
  bit                    no_idle = 1'b0;
  bit                    hold_req = 1'b0;
  logic [63:0]           cfg_shadow [NUM_REGS];

  height_range_classifier u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  hrc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] make_range(input logic signed [HEIGHT_W-1:0] mn,
                                             input logic signed [HEIGHT_W-1:0] mx,
                                             input logic en, input logic [14:0] junk);
    return {junk, en, mx, mn};
  endfunction

  function automatic int idle_len();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 13) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int send_gap();
    if (no_idle || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    return idle_len();
  endfunction

  function automatic int frame_len();
    if ($urandom_range(0, 7) < 6) begin
      return $urandom_range(1, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] rand_bound();
    logic signed [HEIGHT_W-1:0] pick [5];
    pick = '{-100, -10, 0, 10, 100};
    case ($urandom_range(0, 3))
      0: begin
        return pick[$urandom_range(0, 4)];
      end
      1: begin
        return HEIGHT_W'(int'($urandom_range(0, 2000)) - 1000);
      end
      2: begin
        return HEIGHT_W'($urandom());
      end
      default: begin
        return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      end
    endcase
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] pick_height();
    int                         sel;
    logic [63:0]                r;
    logic signed [HEIGHT_W-1:0] b;
    sel = $urandom_range(0, 9);
    r = cfg_shadow[$urandom_range(0, NUM_REGS - 1)];
    b = $urandom_range(0, 1) ? r[REG_MAX_LSB +: HEIGHT_W] : r[REG_MIN_LSB +: HEIGHT_W];
    if (sel < 4) begin
      return HEIGHT_W'(b + int'($urandom_range(0, 2)) - 1);
    end else if (sel < 6) begin
      return HEIGHT_W'(int'($urandom_range(0, 2400)) - 1200);
    end else if (sel < 9) begin
      return HEIGHT_W'($urandom());
    end
    return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
  endfunction

  task automatic send_sample(input logic signed [HEIGHT_W-1:0] h, input logic fend);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= h;
    in_tlast <= fend;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input int idx, input logic [63:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= CFG_ADDR_W'(idx << CFG_IDX_LSB);
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_ranges(input logic [63:0] r0, input logic [63:0] r1,
                             input logic [63:0] r2, input logic [63:0] r3);
    cfg_shadow[0] = r0;
    cfg_shadow[1] = r1;
    cfg_shadow[2] = r2;
    cfg_shadow[3] = r3;
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(1'b1, i, cfg_shadow[i]);
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(1'b0, i, '0);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          fcnt;
    int          flen;
    logic [63:0] rv [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_shadow[i] = '0;
    end
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With every range disabled after reset, nothing matches.
    send_sample(0, 1'b0);
    send_sample(-8388608, 1'b0);
    send_sample(8388607, 1'b1);
    drain();

    // Inverted bounds, overlapping ranges and a disabled range in the middle of the ranking.
    load_ranges(make_range(100, -50, 1'b1, 15'h7FFF), make_range(-8388608, 0, 1'b1, 15'h0),
                make_range(100, 200, 1'b1, 15'h0), make_range(0, 0, 1'b0, 15'h0));
    send_sample(-8388608, 1'b0);
    send_sample(-51, 1'b0);
    send_sample(-50, 1'b0);
    send_sample(0, 1'b0);
    send_sample(99, 1'b0);
    send_sample(100, 1'b0);
    send_sample(199, 1'b0);
    send_sample(200, 1'b0);
    send_sample(201, 1'b0);
    send_sample(8388607, 1'b0);
    send_sample(-1, 1'b1);
    drain();

    // Equal keys are ranked by register index; the top range takes its maximum.
    load_ranges(make_range(10, 20, 1'b1, 15'h0), make_range(20, 10, 1'b1, 15'h1234),
                make_range(10, 20, 1'b0, 15'h0), make_range(30, 8388607, 1'b1, 15'h0));
    send_sample(10, 1'b0);
    send_sample(19, 1'b0);
    send_sample(20, 1'b0);
    send_sample(30, 1'b0);
    send_sample(8388607, 1'b0);
    send_sample(5, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          for (int i = 0; i < NUM_REGS; i++) begin
            rv[i] = make_range(-8388608, 8388607, 1'b1, 15'h0);
          end
        end
        1: begin
          for (int i = 0; i < NUM_REGS; i++) begin
            rv[i] = '1;
          end
        end
        default: begin
          for (int i = 0; i < NUM_REGS; i++) begin
            rv[i] = make_range(rand_bound(), rand_bound(), $urandom_range(0, 3) != 0,
                               15'($urandom()));
          end
        end
      endcase
      load_ranges(rv[0], rv[1], rv[2], rv[3]);
      no_idle = (p == 3);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      fcnt = 0;
      flen = frame_len();
      for (int n = 0; n < 46; n++) begin
        if (p == 5 && n == 23) begin
          drain();
        end
        fcnt++;
        if (fcnt >= flen) begin
          send_sample(pick_height(), 1'b1);
          fcnt = 0;
          flen = frame_len();
        end else begin
          send_sample(pick_height(), 1'b0);
        end
      end
      drain();
      no_idle = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== height_range_classifier.f =====
design/hrc_pkg.sv
design/hrc_cfg.sv
design/hrc_match.sv
design/hrc_core.sv
design/height_range_classifier.sv
tb/sv/hrc_checker.sv
tb/sv/tb.sv
